// ----- hdl/lifo_room_allocator_unit_defines.svh -----
// assertion macros for the lifo room allocator
`ifndef LIFO_ROOM_ALLOCATOR_UNIT_DEFINES_SVH
`define LIFO_ROOM_ALLOCATOR_UNIT_DEFINES_SVH

// same-cycle implication, masked while reset is asserted
`define LRA_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("lra: same-cycle check failed");

// next-cycle implication, masked while reset is asserted
`define LRA_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("lra: next-cycle check failed");

`endif

// ----- hdl/lra_pkg.sv -----
// shared types, constants and helpers for the lifo room allocator
package lra_pkg;

    localparam int ID_W               = 10;
    localparam int ROOM_OUT_W         = 11;
    localparam int DEF_MAX_REQUESTERS = 1024;
    localparam int DEF_MAX_ROOMS      = 1024;
    localparam int RECIP_SH           = 20;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_COMMIT
    } lra_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic reduce;
        logic commit;
    } lra_cmd_t;

    typedef struct packed {
        logic clear_last;
    } lra_status_t;

    // id needs a modulo step when the map is smaller than the id space and not a power of two
    function automatic bit lra_need_mod(input int max_req);
        bit small_map;
        bit pow2;
        small_map = max_req < (1 << ID_W);
        pow2      = (max_req & (max_req - 1)) == 0;
        return small_map && !pow2;
    endfunction

endpackage

// ----- hdl/lra_ctrl.sv -----
// controller state machine: clearing pass, item accept and commit sequencing
module lra_ctrl #(
    parameter int MAX_REQUESTERS = lra_pkg::DEF_MAX_REQUESTERS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  lra_pkg::lra_status_t status,
    output lra_pkg::lra_cmd_t    cmd
);
    import lra_pkg::*;

    localparam bit NEED_MOD = lra_need_mod(MAX_REQUESTERS);

    lra_state_t state_reg;
    lra_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = NEED_MOD ? ST_REDUCE : ST_COMMIT;
            end
            ST_REDUCE:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
            end
            ST_COMMIT:
            begin
                // hold the item until the output register is free
                cmd.commit = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/lra_datapath.sv -----
// datapath: room map, free stack, counters and result register
module lra_datapath #(
    parameter int MAX_REQUESTERS = lra_pkg::DEF_MAX_REQUESTERS,
    parameter int MAX_ROOMS      = lra_pkg::DEF_MAX_ROOMS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lra_pkg::lra_cmd_t             cmd,
    output lra_pkg::lra_status_t          status,
    input  logic [lra_pkg::ID_W-1:0]       requester_id,
    output logic [lra_pkg::ROOM_OUT_W-1:0] room,
    output logic                          departed,
    output logic [lra_pkg::ROOM_OUT_W-1:0] rooms_created,
    output logic                          exhausted
);
    import lra_pkg::*;

    localparam bit NEED_MOD    = lra_need_mod(MAX_REQUESTERS);
    localparam int MAP_DEPTH   = (MAX_REQUESTERS < (1 << ID_W)) ? MAX_REQUESTERS : (1 << ID_W);
    localparam int IDX_W       = $clog2(MAP_DEPTH);
    localparam int ROOM_W      = $clog2(MAX_ROOMS + 1);
    localparam int SIDX_W      = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int STACK_DEPTH = 1 << SIDX_W;

    logic [ROOM_W-1:0] map_mem   [MAP_DEPTH];
    logic [ROOM_W-1:0] stack_mem [STACK_DEPTH];

    logic [IDX_W-1:0]  rd_idx;
    logic              rd_en;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [ROOM_W-1:0] held_q;
    logic [ROOM_W-1:0] top_q;
    logic [SIDX_W-1:0] top_idx;
    logic [SIDX_W-1:0] push_idx;

    logic [ROOM_W-1:0] free_cnt_reg;
    logic [ROOM_W-1:0] free_cnt_next;
    logic [ROOM_W-1:0] created_reg;
    logic [ROOM_W-1:0] created_next;
    logic [ROOM_W-1:0] room_reg;
    logic [ROOM_W-1:0] room_next;
    logic              departed_reg;
    logic              exhausted_reg;
    logic              exhausted_next;

    logic              arrival;
    logic              push;
    logic [ROOM_W-1:0] grant;

    logic              map_we;
    logic [IDX_W-1:0]  map_waddr;
    logic [ROOM_W-1:0] map_wdata;

    generate
        if (NEED_MOD)
        begin : g_mod
            localparam int RECIP = (1 << RECIP_SH) / MAX_REQUESTERS;
            localparam int PW    = RECIP_SH + ID_W;

            logic [ID_W-1:0]   id_reg;
            logic [ID_W-1:0]   q_reg;
            logic [PW-1:0]     prod;
            logic [2*ID_W-1:0] qm;
            logic [ID_W-1:0]   rem0;
            logic [ID_W-1:0]   rem1;

            // quotient estimate by reciprocal, low by at most one
            assign prod = PW'(requester_id) * PW'(RECIP);

            always_ff @(posedge clk)
            begin
                if (cmd.accept)
                begin
                    id_reg <= requester_id;
                    q_reg  <= prod[PW-1:RECIP_SH];
                end
            end

            assign qm     = (2*ID_W)'(q_reg) * (2*ID_W)'(MAX_REQUESTERS);
            assign rem0   = id_reg - qm[ID_W-1:0];
            assign rem1   = (rem0 >= ID_W'(MAX_REQUESTERS)) ?
                            rem0 - ID_W'(MAX_REQUESTERS) : rem0;
            assign rd_idx = rem1[IDX_W-1:0];
            assign rd_en  = cmd.reduce;
        end
        else
        begin : g_direct
            assign rd_idx = requester_id[IDX_W-1:0];
            assign rd_en  = cmd.accept;
        end
    endgenerate

    assign top_idx  = SIDX_W'(free_cnt_reg - 1'b1);
    assign push_idx = free_cnt_reg[SIDX_W-1:0];

    // decision for the item whose lookups are held in held_q and top_q
    always_comb
    begin
        arrival        = (held_q == '0);
        free_cnt_next  = free_cnt_reg;
        created_next   = created_reg;
        grant          = '0;
        exhausted_next = 1'b0;
        push           = 1'b0;
        if (arrival)
        begin
            if (free_cnt_reg != '0)
            begin
                grant         = top_q;
                free_cnt_next = free_cnt_reg - 1'b1;
            end
            else if (created_reg < ROOM_W'(MAX_ROOMS))
            begin
                created_next = created_reg + 1'b1;
                grant        = created_next;
            end
            else
            begin
                exhausted_next = 1'b1;
            end
        end
        else if (free_cnt_reg < ROOM_W'(MAX_ROOMS))
        begin
            push          = 1'b1;
            free_cnt_next = free_cnt_reg + 1'b1;
        end
        room_next = arrival ? grant : held_q;
    end

    assign map_we    = cmd.clear || cmd.commit;
    assign map_waddr = cmd.clear ? clr_idx_reg : idx_reg;
    assign map_wdata = (cmd.clear || !arrival) ? '0 : grant;

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (rd_en)
            held_q <= map_mem[rd_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && push)
            stack_mem[push_idx] <= held_q;
        if (rd_en)
            top_q <= stack_mem[top_idx];
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            idx_reg <= rd_idx;
        if (cmd.commit)
        begin
            room_reg      <= room_next;
            departed_reg  <= !arrival;
            exhausted_reg <= exhausted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_cnt_reg <= '0;
            created_reg  <= '0;
            clr_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.commit)
            begin
                free_cnt_reg <= free_cnt_next;
                created_reg  <= created_next;
            end
            if (cmd.clear)
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign status.clear_last = (clr_idx_reg == IDX_W'(MAP_DEPTH - 1));

    // created count only moves on a commit, which waits for the result to go
    assign room          = ROOM_OUT_W'(room_reg);
    assign departed      = departed_reg;
    assign rooms_created = ROOM_OUT_W'(created_reg);
    assign exhausted     = exhausted_reg;

endmodule

// ----- hdl/lifo_room_allocator_unit.sv -----
// LIFO free-list room allocator. Each item carries a requester id; an id with no room
// is an arrival and gets the most recently freed room, or else a newly created room,
// or room 0 with exhausted set when MAX_ROOMS rooms exist and none is free. An id
// holding a room is a departure: its room is freed onto the stack. One result per
// item. An item takes a map and stack lookup, then a commit, when
// MAX_REQUESTERS is a power of two or at least 1024; otherwise the lookup is
// made in an added reduce step that reduces the id modulo MAX_REQUESTERS. One
// item is in flight at a time; a finished result waits in the output register
// while the next item is taken, and commit stalls only if that register is still
// full. After reset the room map's min(MAX_REQUESTERS, 1024) entries are cleared
// one entry a cycle, during which no item is accepted.
`include "lifo_room_allocator_unit_defines.svh"

module lifo_room_allocator_unit #(
    parameter int MAX_REQUESTERS = lra_pkg::DEF_MAX_REQUESTERS,
    parameter int MAX_ROOMS      = lra_pkg::DEF_MAX_ROOMS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [lra_pkg::ID_W-1:0]       requester_id,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lra_pkg::ROOM_OUT_W-1:0] room,
    output logic                          departed,
    output logic [lra_pkg::ROOM_OUT_W-1:0] rooms_created,
    output logic                          exhausted
);
    import lra_pkg::*;

    lra_cmd_t    ctrl_cmd;
    lra_status_t dp_status;

    lra_ctrl #(
        .MAX_REQUESTERS (MAX_REQUESTERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    lra_datapath #(
        .MAX_REQUESTERS (MAX_REQUESTERS),
        .MAX_ROOMS      (MAX_ROOMS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ctrl_cmd),
        .status        (dp_status),
        .requester_id  (requester_id),
        .room          (room),
        .departed      (departed),
        .rooms_created (rooms_created),
        .exhausted     (exhausted)
    );

    `LRA_ASSERT_IMPL(a_exhausted_no_room, clk, rst_n, out_valid && exhausted, room == '0 && !departed)
    `LRA_ASSERT_IMPL(a_departure_frees_room, clk, rst_n, out_valid && departed, room != '0)
    `LRA_ASSERT_NEXT(a_one_item_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    `LRA_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, ctrl_cmd.commit, out_valid)

endmodule
